@@ hw/rtl/bcc_pkg.sv @@
package bcc_pkg;

   localparam int unsigned TICK_W = 16;

   // button_status codes
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_PRESSED = 2'd1;
   localparam logic [1:0] ST_CLICKED = 2'd2;
   localparam logic [1:0] ST_DOUBLE  = 2'd3;

   // register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_EFFECT   = 1'b1;

   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TICK_W-1:0] EFFECT_RESET   = 16'd500;

   localparam logic [1:0] CLICK_MAX = 2'd3;

   // timer expiries seen in the current tick
   typedef struct packed {
      logic effect_expire;
      logic debounce_expire;
   } timer_evt_type;

   // timer start requests raised in the current tick
   typedef struct packed {
      logic effect_start;
      logic debounce_start;
   } timer_start_type;

endpackage

@@ hw/rtl/bcc_timer.sv @@
module bcc_timer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       start,
   input  logic [bcc_pkg::TICK_W-1:0] load,
   output logic                       expire
);
   import bcc_pkg::*;

   logic [TICK_W-1:0] left_ff, left_in;
   logic              running_ff, running_in;

   // expiry is seen before a start in the same tick, so a timer that ends
   // this tick may be restarted at once
   assign expire = step && running_ff && (left_ff == TICK_W'(1));

   always_comb begin
      left_in    = left_ff;
      running_in = running_ff;
      if (step) begin
         if (running_ff) begin
            left_in = left_ff - TICK_W'(1);
         end
         if (expire) begin
            running_in = 1'b0;
         end
         if (start && (!running_ff || expire)) begin
            left_in    = load;
            running_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         running_ff <= 1'b0;
      end else begin
         left_ff    <= left_in;
         running_ff <= running_in;
      end
   end

endmodule

@@ hw/rtl/bcc_classifier.sv @@
module bcc_classifier (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     button_level,
   input  logic                     ack_click,
   input  logic                     ack_double,
   input  bcc_pkg::timer_evt_type   evt,
   output bcc_pkg::timer_start_type starts,
   output logic [1:0]               button_status,
   output logic                     click_taken,
   output logic                     double_taken
);
   import bcc_pkg::*;

   logic       last_level_ff, last_level_in;
   logic       contact_ff, contact_in;
   logic [1:0] status_ff, status_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      status_in     = status_ff;
      contact_in    = contact_ff;
      count_in      = count_ff;
      last_level_in = button_level;
      click_taken   = 1'b0;
      double_taken  = 1'b0;

      // effect timer classifies first
      if (evt.effect_expire) begin
         if (status_in == ST_IDLE && contact_in && button_level) begin
            status_in = ST_PRESSED;
         end else if (count_in == 2'd1) begin
            status_in = ST_CLICKED;
            count_in  = '0;
         end else if (count_in > 2'd1) begin
            status_in = ST_DOUBLE;
            count_in  = '0;
         end
      end

      // debounced sample: drop stale click status, then track contact
      if (evt.debounce_expire) begin
         if (status_in == ST_CLICKED || status_in == ST_DOUBLE) begin
            status_in = ST_IDLE;
         end
         if (status_in == ST_IDLE && !contact_in && button_level) begin
            contact_in = 1'b1;
         end else if (status_in == ST_IDLE && contact_in && !button_level) begin
            contact_in = 1'b0;
            if (count_in != CLICK_MAX) begin
               count_in = count_in + 2'd1;
            end
         end else if (status_in == ST_PRESSED && contact_in && !button_level) begin
            status_in  = ST_IDLE;
            contact_in = 1'b0;
         end
      end

      // read-to-clear
      if (ack_click && status_in == ST_CLICKED) begin
         status_in   = ST_IDLE;
         click_taken = 1'b1;
      end
      if (ack_double && status_in == ST_DOUBLE) begin
         status_in    = ST_IDLE;
         double_taken = 1'b1;
      end

      starts.effect_start   = evt.debounce_expire;
      starts.debounce_start = step && (button_level != last_level_ff);
      button_status         = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         contact_ff    <= 1'b0;
         status_ff     <= ST_IDLE;
         count_ff      <= '0;
      end else if (step) begin
         last_level_ff <= last_level_in;
         contact_ff    <= contact_in;
         status_ff     <= status_in;
         count_ff      <= count_in;
      end
   end

endmodule

@@ hw/rtl/button_click_classifier.sv @@
// channel   | dir | handshake             | payload
// ----------+-----+-----------------------+--------------------------------------
// req_      | in  | req_tvalid/req_tready | tdata: button_level, ack_click, ack_double
// rsp_      | out | rsp_tvalid/rsp_tready | tdata: button_status, click_taken, double_taken
// csr_      | in  | csr_we                | csr_index, csr_wdata (16 bit)
//
// One request per clock unless a stalled response holds req_tready low: the tick
// update is a single pass of compare and decrement logic feeding the response register.
// Reset is synchronous; timers idle, status idle, delays back to 50 / 500.
// A stalled response holds; req_tready stays high while the response
// register is empty or being drained in the same cycle.
module button_click_classifier (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [1] ack_click, [2] ack_double

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] button_status, [2] click_taken, [3] double_taken

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import bcc_pkg::*;

   logic [TICK_W-1:0] debounce_ticks_ff, effect_ticks_ff;
   logic [TICK_W-1:0] debounce_load, effect_load;

   logic              step;
   timer_evt_type     evt;
   timer_start_type   starts;
   logic [1:0]        status;
   logic              took_click, took_double;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_data_ff;

   // delay registers; a zero load acts as one tick
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         effect_ticks_ff   <= EFFECT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ticks_ff <= csr_wdata;
            CSR_EFFECT:   effect_ticks_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   assign debounce_load = (debounce_ticks_ff == '0) ? TICK_W'(1) : debounce_ticks_ff;
   assign effect_load   = (effect_ticks_ff == '0) ? TICK_W'(1) : effect_ticks_ff;

   // accept whenever the response slot is free or empties this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   bcc_timer u_effect (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .start  (starts.effect_start),
      .load   (effect_load),
      .expire (evt.effect_expire)
   );

   bcc_timer u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .start  (starts.debounce_start),
      .load   (debounce_load),
      .expire (evt.debounce_expire)
   );

   bcc_classifier u_class (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .button_level  (req_tdata[0]),
      .ack_click     (req_tdata[1]),
      .ack_double    (req_tdata[2]),
      .evt           (evt),
      .starts        (starts),
      .button_status (status),
      .click_taken   (took_click),
      .double_taken  (took_double)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {took_double, took_click, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

@@ hw/rtl/bcc_checker.sv @@
module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import bcc_pkg::*;

   // response register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty response slot never backpressures requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response slot");

   // both acks cannot clear in the same tick
   a_one_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("click and double click both taken");

   // a taken click or double click leaves the status idle
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]) |-> rsp_tdata[1:0] == ST_IDLE)
      else $error("status not idle after acknowledge");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
